// ===== sv/fdd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdd_pkg
// Types, widths and helper functions for the three-component power
// decomposition pipeline.
// ----------------------------------------------------------------------------
package fdd_pkg;

  // Branch codes reported with every result item.
  localparam logic [1:0] BR_SURFACE = 2'd0;
  localparam logic [1:0] BR_DOUBLE  = 2'd1;
  localparam logic [1:0] BR_NONE    = 2'd2;

  // Datapath widths.
  localparam int ExtW   = 36;  // signed working width of the stage-one sums
  localparam int MagW   = 35;  // magnitude of the complex real parts
  localparam int LoW    = 18;  // low half of a split magnitude
  localparam int HiW    = 17;  // high half of a split magnitude
  localparam int SqW    = 72;  // squared magnitudes, their sum and difference
  localparam int ChunkW = 24;  // slice of a squared magnitude per multiplier
  localparam int DmagW  = 31;  // magnitude of hh minus vv
  localparam int NumW   = 103; // |d| times a squared magnitude
  localparam int QW     = 32;  // quotient bits kept
  localparam int DivN   = 32;  // one quotient bit per divider stage

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  // Per item flags and side data that travel with the datapath.
  typedef struct packed {
    logic [1:0]        branch;
    logic signed [33:0] vvp;
    logic [30:0]       vol;
    logic              vol_flt;
    logic              d_neg;
    logic              b_neg;
    logic              p_zero;
    logic              dz;
    logic              nz_i;
    logic              nz_o;
    logic              ovf_i;
    logic              ovf_o;
  } flags_t;

  // Payload of one divider stage.
  typedef struct packed {
    logic [NumW-1:0] rem_i;
    logic [NumW-1:0] rem_o;
    logic [QW-1:0]   q_i;
    logic [QW-1:0]   q_o;
    logic [SqW-1:0]  diff;
    flags_t          f;
  } div_t;

  // Signed, clamped quotient of one ratio with its fault flag in bit 32.
  function automatic logic [32:0] fdd_ratio(input logic [QW-1:0] q, input logic ovf,
                                            input logic dz, input logic nz,
                                            input logic d_neg, input logic b_neg);
    logic              neg;
    logic [QW-1:0]     limit;
    logic [QW-1:0]     mag;
    logic              flt;
    logic signed [31:0] val;
    neg   = d_neg ^ b_neg;
    limit = neg ? 32'h80000000 : 32'h7fffffff;
    flt   = 1'b0;
    mag   = q;
    if (dz) begin
      flt = 1'b1;
      val = nz ? 32'sd0 : (d_neg ? SAT_MIN : SAT_MAX);
    end else begin
      if (ovf || (q > limit)) begin
        flt = 1'b1;
        mag = limit;
      end
      val = neg ? $signed(32'd0 - mag) : $signed(mag);
    end
    return {flt, val};
  endfunction

endpackage

// ===== sv/freeman_durden_decomposition_unit.sv =====
// ----------------------------------------------------------------------------
// freeman_durden_decomposition_unit
// Pipelined three-component (surface, double-bounce, volume) decomposition of
// one polarimetric pixel in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// The unit takes one pixel item per clock while in_stall is low and returns
// one result item per pixel, in order, in the output register. The datapath
// has six stages of setup, squaring, partial products and sums, one overflow
// check, and a 32-stage restoring divider that produces one quotient bit per
// stage for both ratios in parallel, followed by the output register. A stall
// on the result side freezes the whole pipeline and is passed back to the
// input side.
module freeman_durden_decomposition_unit
  import fdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [30:0]        in_hh_power,
  input  logic [30:0]        in_vv_power,
  input  logic [30:0]        in_hv_power,
  input  logic signed [31:0] in_hhvv_real,
  input  logic signed [31:0] in_hhvv_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_surface_power,
  output logic signed [31:0] out_double_bounce_power,
  output logic [30:0]        out_volume_power,
  output logic [1:0]         out_branch_taken,
  output logic               out_arith_fault
);

  logic en;
  logic out_valid_r;

  // The pipeline moves whenever the output register can take a new item.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Threshold register.
  logic [15:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd1;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Stage 1: remove the volume part, pick the branch, form the magnitudes.
  logic signed [ExtW-1:0] hh_s, vv_s, hv_s, hr_s, hi_s, thr_s;
  logic signed [ExtW-1:0] hhp, vvp, cr, nr, mr, d, nabs, mabs, iabs, dabs;
  flags_t s1_f_nxt;

  always_comb begin
    hh_s  = $signed({5'd0, in_hh_power});
    vv_s  = $signed({5'd0, in_vv_power});
    hv_s  = $signed({5'd0, in_hv_power});
    hr_s  = {{4{in_hhvv_real[31]}}, in_hhvv_real};
    hi_s  = {{4{in_hhvv_imag[31]}}, in_hhvv_imag};
    thr_s = $signed({20'd0, thr_r});
    hhp   = hh_s - hv_s - (hv_s <<< 1);
    vvp   = vv_s - hv_s - (hv_s <<< 1);
    cr    = hr_s - hv_s;
    d     = hh_s - vv_s;
    s1_f_nxt = '0;
    if (hr_s > thr_s) begin
      s1_f_nxt.branch = BR_SURFACE;
    end else if (hr_s < -thr_s) begin
      s1_f_nxt.branch = BR_DOUBLE;
    end else begin
      s1_f_nxt.branch = BR_NONE;
    end
    nr   = (s1_f_nxt.branch == BR_DOUBLE) ? (vvp - cr) : (vvp + cr);
    mr   = (s1_f_nxt.branch == BR_DOUBLE) ? (hhp - cr) : (hhp + cr);
    nabs = nr[ExtW-1] ? -nr : nr;
    mabs = mr[ExtW-1] ? -mr : mr;
    iabs = hi_s[ExtW-1] ? -hi_s : hi_s;
    dabs = d[ExtW-1] ? -d : d;
    s1_f_nxt.vvp     = vvp[33:0];
    s1_f_nxt.d_neg   = d[ExtW-1];
    s1_f_nxt.vol_flt = (in_hv_power[30:28] != 3'd0);
    s1_f_nxt.vol     = s1_f_nxt.vol_flt ? 31'h7fffffff : {in_hv_power[27:0], 3'd0};
  end

  logic              s1_v_r;
  flags_t            s1_f_r;
  logic [MagW-1:0]   s1_n_r, s1_m_r;
  logic [31:0]       s1_i_r;
  logic [DmagW-1:0]  s1_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_f_r <= s1_f_nxt;
      s1_n_r <= nabs[MagW-1:0];
      s1_m_r <= mabs[MagW-1:0];
      s1_i_r <= iabs[31:0];
      s1_d_r <= dabs[DmagW-1:0];
    end
  end

  // Stage 2: partial products of the squares on split magnitudes.
  logic                s2_v_r;
  flags_t              s2_f_r;
  logic [2*HiW-1:0]    s2_nhh_r, s2_mhh_r;
  logic [HiW+LoW-1:0]  s2_nhl_r, s2_mhl_r;
  logic [2*LoW-1:0]    s2_nll_r, s2_mll_r;
  logic [63:0]         s2_ii_r;
  logic [DmagW-1:0]    s2_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_f_r   <= s1_f_r;
      s2_nhh_r <= (2*HiW)'(s1_n_r[MagW-1:LoW]) * (2*HiW)'(s1_n_r[MagW-1:LoW]);
      s2_nhl_r <= (HiW+LoW)'(s1_n_r[MagW-1:LoW]) * (HiW+LoW)'(s1_n_r[LoW-1:0]);
      s2_nll_r <= (2*LoW)'(s1_n_r[LoW-1:0]) * (2*LoW)'(s1_n_r[LoW-1:0]);
      s2_mhh_r <= (2*HiW)'(s1_m_r[MagW-1:LoW]) * (2*HiW)'(s1_m_r[MagW-1:LoW]);
      s2_mhl_r <= (HiW+LoW)'(s1_m_r[MagW-1:LoW]) * (HiW+LoW)'(s1_m_r[LoW-1:0]);
      s2_mll_r <= (2*LoW)'(s1_m_r[LoW-1:0]) * (2*LoW)'(s1_m_r[LoW-1:0]);
      s2_ii_r  <= 64'(s1_i_r) * 64'(s1_i_r);
      s2_d_r   <= s1_d_r;
    end
  end

  // Stage 3: squared magnitudes P and Q.
  logic [SqW-1:0] p_nxt, q_nxt;
  always_comb begin
    p_nxt = (SqW'(s2_nhh_r) << (2 * LoW)) + (SqW'(s2_nhl_r) << (LoW + 1))
          + SqW'(s2_nll_r) + SqW'(s2_ii_r);
    q_nxt = (SqW'(s2_mhh_r) << (2 * LoW)) + (SqW'(s2_mhl_r) << (LoW + 1))
          + SqW'(s2_mll_r) + SqW'(s2_ii_r);
  end

  logic             s3_v_r;
  flags_t           s3_f_r;
  logic [SqW-1:0]   s3_p_r, s3_q_r;
  logic [DmagW-1:0] s3_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_f_r <= s2_f_r;
      s3_p_r <= p_nxt;
      s3_q_r <= q_nxt;
      s3_d_r <= s2_d_r;
    end
  end

  // Stage 4: divisor |Q - P| with its sign, and the sum P + Q.
  flags_t s4_f_nxt;
  always_comb begin
    s4_f_nxt        = s3_f_r;
    s4_f_nxt.b_neg  = (s3_q_r < s3_p_r);
    s4_f_nxt.p_zero = (s3_p_r == '0);
  end

  logic             s4_v_r;
  flags_t           s4_f_r;
  logic [SqW-1:0]   s4_p_r, s4_sum_r, s4_diff_r;
  logic [DmagW-1:0] s4_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_f_r    <= s4_f_nxt;
      s4_p_r    <= s3_p_r;
      s4_sum_r  <= s3_p_r + s3_q_r;
      s4_diff_r <= s4_f_nxt.b_neg ? (s3_p_r - s3_q_r) : (s3_q_r - s3_p_r);
      s4_d_r    <= s3_d_r;
    end
  end

  // Stage 5: |d| times each numerator factor, in three slices.
  localparam int PpW = DmagW + ChunkW;

  logic             s5_v_r;
  flags_t           s5_f_r;
  logic [PpW-1:0]   s5_pi_r [3];
  logic [PpW-1:0]   s5_po_r [3];
  logic [SqW-1:0]   s5_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_f_r    <= s4_f_r;
      s5_diff_r <= s4_diff_r;
      for (int k = 0; k < 3; k++) begin
        s5_pi_r[k] <= PpW'(s4_d_r) * PpW'(s4_p_r[k*ChunkW +: ChunkW]);
        s5_po_r[k] <= PpW'(s4_d_r) * PpW'(s4_sum_r[k*ChunkW +: ChunkW]);
      end
    end
  end

  // Stage 6: assemble the numerators and note the zero cases.
  logic [NumW-1:0] num_i_nxt, num_o_nxt;
  flags_t          s6_f_nxt;
  always_comb begin
    num_i_nxt = NumW'(s5_pi_r[0]) + (NumW'(s5_pi_r[1]) << ChunkW)
              + (NumW'(s5_pi_r[2]) << (2 * ChunkW));
    num_o_nxt = NumW'(s5_po_r[0]) + (NumW'(s5_po_r[1]) << ChunkW)
              + (NumW'(s5_po_r[2]) << (2 * ChunkW));
    s6_f_nxt      = s5_f_r;
    s6_f_nxt.dz   = (s5_diff_r == '0);
    s6_f_nxt.nz_i = (num_i_nxt == '0);
    s6_f_nxt.nz_o = (num_o_nxt == '0);
  end

  logic            s6_v_r;
  flags_t          s6_f_r;
  logic [NumW-1:0] s6_ni_r, s6_no_r;
  logic [SqW-1:0]  s6_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_f_r    <= s6_f_nxt;
      s6_ni_r   <= num_i_nxt;
      s6_no_r   <= num_o_nxt;
      s6_diff_r <= s5_diff_r;
    end
  end

  // Stage 7: a quotient of 2^32 or more saturates; load the divider.
  logic [NumW-1:0] dsh;
  div_t            div_r [DivN+1];
  logic [DivN:0]   div_v_r;
  div_t            div0_nxt;

  always_comb begin
    dsh                = NumW'(s6_diff_r) << QW;
    div0_nxt.rem_i     = s6_ni_r;
    div0_nxt.rem_o     = s6_no_r;
    div0_nxt.q_i       = '0;
    div0_nxt.q_o       = '0;
    div0_nxt.diff      = s6_diff_r;
    div0_nxt.f         = s6_f_r;
    div0_nxt.f.ovf_i   = (s6_ni_r >= dsh);
    div0_nxt.f.ovf_o   = (s6_no_r >= dsh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v_r[0] <= 1'b0;
    end else if (en) begin
      div_v_r[0] <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= div0_nxt;
    end
  end

  // Restoring divider: each stage settles one quotient bit of both ratios.
  for (genvar k = 0; k < DivN; k++) begin : g_div
    localparam int Bit = DivN - 1 - k;
    logic [NumW-1:0] sh;
    div_t            div_nxt;

    always_comb begin
      sh      = NumW'(div_r[k].diff) << Bit;
      div_nxt = div_r[k];
      if (div_r[k].rem_i >= sh) begin
        div_nxt.rem_i    = div_r[k].rem_i - sh;
        div_nxt.q_i[Bit] = 1'b1;
      end
      if (div_r[k].rem_o >= sh) begin
        div_nxt.rem_o    = div_r[k].rem_o - sh;
        div_nxt.q_o[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[k+1] <= 1'b0;
      end else if (en) begin
        div_v_r[k+1] <= div_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k+1] <= div_nxt;
      end
    end
  end

  // Final stage: clamp the ratios, form the other power, assign by branch.
  div_t               fin;
  logic [32:0]        r_i, r_o;
  logic signed [37:0] other_w;
  logic signed [31:0] other;
  logic               other_flt;
  logic signed [31:0] surf_nxt, dbl_nxt;
  logic [30:0]        vol_nxt;
  logic [1:0]         br_nxt;
  logic               flt_nxt;

  always_comb begin
    fin     = div_r[DivN];
    r_i     = fdd_ratio(fin.q_i, fin.f.ovf_i, fin.f.dz, fin.f.nz_i,
                        fin.f.d_neg, fin.f.b_neg);
    r_o     = fdd_ratio(fin.q_o, fin.f.ovf_o, fin.f.dz, fin.f.nz_o,
                        fin.f.d_neg, fin.f.b_neg);
    other_w = (38'(fin.f.vvp) - 38'($signed(r_i[31:0]))) <<< 1;
    other_flt = 1'b0;
    if (other_w > 38'(SAT_MAX)) begin
      other     = SAT_MAX;
      other_flt = 1'b1;
    end else if (other_w < 38'(SAT_MIN)) begin
      other     = SAT_MIN;
      other_flt = 1'b1;
    end else begin
      other = other_w[31:0];
    end
    br_nxt = fin.f.branch;
    case (fin.f.branch)
      BR_SURFACE: begin
        surf_nxt = $signed(r_o[31:0]);
        dbl_nxt  = other;
      end
      BR_DOUBLE: begin
        surf_nxt = other;
        dbl_nxt  = $signed(r_o[31:0]);
      end
      default: begin
        surf_nxt = '0;
        dbl_nxt  = '0;
        br_nxt   = BR_NONE;
      end
    endcase
    if (br_nxt == BR_NONE) begin
      vol_nxt = '0;
      flt_nxt = 1'b0;
    end else begin
      vol_nxt = fin.f.vol;
      flt_nxt = fin.f.p_zero | r_i[32] | r_o[32] | other_flt | fin.f.vol_flt;
    end
  end

  // Output register.
  logic signed [31:0] out_surf_r, out_dbl_r;
  logic [30:0]        out_vol_r;
  logic [1:0]         out_br_r;
  logic               out_flt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_v_r[DivN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_surf_r <= surf_nxt;
      out_dbl_r  <= dbl_nxt;
      out_vol_r  <= vol_nxt;
      out_br_r   <= br_nxt;
      out_flt_r  <= flt_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_surface_power       = out_surf_r;
  assign out_double_bounce_power = out_dbl_r;
  assign out_volume_power        = out_vol_r;
  assign out_branch_taken        = out_br_r;
  assign out_arith_fault         = out_flt_r;

endmodule
